// ===== src/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the battery monitor filter
// Holds the field widths, the register defaults and indexes, the sequencer
// state type, the command and status structs, and the divide-by-ten helper.
// ----------------------------------------------------------------------------
package bmf_pkg;

  // Default ADC resolution of the voltage channel.
  localparam int unsigned AdcBitsDef = 10;

  // Fixed field widths.
  localparam int unsigned CurW  = 10;
  localparam int unsigned MvW   = 15;
  localparam int unsigned CntW  = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  // Register indexes.
  localparam logic [IdxW-1:0] RegFullScale = 2'd0;
  localparam logic [IdxW-1:0] RegLowThresh = 2'd1;
  localparam logic [IdxW-1:0] RegDebLimit  = 2'd2;

  // Register reset values.
  localparam logic [MvW-1:0]  FullScaleRst = 15'd10000;
  localparam logic [MvW-1:0]  LowThreshRst = 15'd4000;
  localparam logic [CntW-1:0] DebLimitRst  = 16'd600;

  // Division by ten through a reciprocal: exact for all operands below 2^20, the full input width.
  localparam int unsigned DivInW   = 20;
  localparam int unsigned DivShift = 23;
  localparam logic [DivInW-1:0] DivRecip = 20'd838861;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIFF,
    ST_DIV,
    ST_CNT
  } bmf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic diff_en;
    logic div_en;
    logic commit;
  } bmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } bmf_status_t;

  // Unsigned quotient of n by ten, truncating.
  function automatic logic [DivInW-4:0] div10(input logic [DivInW-1:0] n);
    logic [2*DivInW-1:0] prod;
    prod  = n * DivRecip;
    div10 = prod[DivShift +: DivInW-3];
  endfunction

endpackage

// ===== src/bmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmf_ctrl: sequencer of the battery monitor filter
// Walks each sample through scaling, difference, division and the counter
// update, and holds the last step until the output register is free.
// ----------------------------------------------------------------------------
module bmf_ctrl
  import bmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  bmf_status_t status_i,
  output bmf_cmd_t    cmd_o,
  output logic        in_stall_o
);

  bmf_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = ST_CNT;
      end
      ST_CNT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bmf_datapath.sv =====
// ----------------------------------------------------------------------------
// bmf_datapath: arithmetic and storage of the battery monitor filter
// Holds the configuration registers, the two filter averages, the debounce
// counter and the output register, and performs one step per command.
// ----------------------------------------------------------------------------
module bmf_datapath
  import bmf_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmf_cmd_t            cmd_i,
  output bmf_status_t         status_o,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [ADC_BITS-1:0] raw_voltage_i,
  input  logic [CurW-1:0]     raw_current_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MvW-1:0]      filtered_voltage_mv_o,
  output logic [CurW-1:0]     filtered_current_ma_o,
  output logic                battery_low_o
);

  localparam int unsigned ProdW = ADC_BITS + MvW;

  logic [MvW-1:0]      full_scale_q, low_thresh_q;
  logic [CntW-1:0]     deb_limit_q;
  logic [ADC_BITS-1:0] rv_q;
  logic [CurW-1:0]     rc_q;
  logic [MvW-1:0]      mv_q;
  logic [MvW-1:0]      vavg_q, vavg_d;
  logic [CurW-1:0]     cavg_q, cavg_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                vneg_q, cneg_q;
  logic [DivInW-1:0]   v9_q, c9_q;
  logic                out_valid_q;
  logic [MvW-1:0]      out_mv_q;
  logic [CurW-1:0]     out_ma_q;
  logic                out_low_q;

  logic [ProdW-1:0]    prod;
  logic [MvW:0]        vdiff, vmag;
  logic [CurW:0]       cdiff, cmag;
  logic [DivInW-4:0]   vquo, cquo;
  logic                below;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FullScaleRst;
      low_thresh_q <= LowThreshRst;
      deb_limit_q  <= DebLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFullScale: full_scale_q <= cfg_data_i[MvW-1:0];
        RegLowThresh: low_thresh_q <= cfg_data_i[MvW-1:0];
        RegDebLimit:  deb_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scaling of the voltage code to millivolts.
  assign prod = ProdW'(rv_q) * ProdW'(full_scale_q);

  // Signed differences and their magnitudes.
  assign vdiff = {1'b0, mv_q} - {1'b0, vavg_q};
  assign vmag  = vdiff[MvW] ? -vdiff : vdiff;
  assign cdiff = {1'b0, rc_q} - {1'b0, cavg_q};
  assign cmag  = cdiff[CurW] ? -cdiff : cdiff;

  // Quotients by ten, then the filter update with the sign restored.
  assign vquo   = div10(v9_q);
  assign cquo   = div10(c9_q);
  assign vavg_d = vneg_q ? vavg_q - vquo[MvW-1:0] : vavg_q + vquo[MvW-1:0];
  assign cavg_d = cneg_q ? cavg_q - cquo[CurW-1:0] : cavg_q + cquo[CurW-1:0];

  // Saturating debounce counter.
  assign below = vavg_q < low_thresh_q;
  always_comb begin
    cnt_d = cnt_q;
    if (below) begin
      if (cnt_q < deb_limit_q) begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Working registers of one sample.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rv_q <= raw_voltage_i;
      rc_q <= raw_current_i;
    end
    if (cmd_i.mul_en) begin
      mv_q <= prod[ADC_BITS +: MvW];
    end
    if (cmd_i.diff_en) begin
      vneg_q <= vdiff[MvW];
      cneg_q <= cdiff[CurW];
      v9_q   <= (DivInW'(vmag) << 3) + DivInW'(vmag);
      c9_q   <= (DivInW'(cmag) << 3) + DivInW'(cmag);
    end
  end

  // Filter state and counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vavg_q <= '0;
      cavg_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.div_en) begin
        vavg_q <= vavg_d;
        cavg_q <= cavg_d;
      end
      if (cmd_i.commit) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_mv_q  <= vavg_q;
      out_ma_q  <= cavg_q;
      out_low_q <= cnt_d >= deb_limit_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign filtered_voltage_mv_o = out_mv_q;
  assign filtered_current_ma_o = out_ma_q;
  assign battery_low_o         = out_low_q;

endmodule

// ===== src/battery_monitor_filter.sv =====
// A result is placed in the output register once its sample has passed through
// the sequencer that walks scaling, difference, division and counter update in
// turn; no new sample is taken until then, and a stalled result holds the last
// step until the output register is free.
// Reset: asynchronous, active low; clears the averages, the counter, the output
// valid flag and the control state, and loads the register defaults.
// ----------------------------------------------------------------------------
// battery_monitor_filter: top level
// Scales the battery voltage code, low-pass filters voltage and current, and
// debounces the low-voltage condition into a battery-low flag.
// ----------------------------------------------------------------------------
module battery_monitor_filter
  import bmf_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ADC_BITS-1:0] raw_voltage_i,
  input  logic [CurW-1:0]     raw_current_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [MvW-1:0]      filtered_voltage_mv_o,
  output logic [CurW-1:0]     filtered_current_ma_o,
  output logic                battery_low_o
);

  bmf_cmd_t    cmd;
  bmf_status_t status;

  // Sequencer.
  bmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Arithmetic and storage.
  bmf_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .raw_voltage_i         (raw_voltage_i),
    .raw_current_i         (raw_current_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .filtered_voltage_mv_o (filtered_voltage_mv_o),
    .filtered_current_ma_o (filtered_current_ma_o),
    .battery_low_o         (battery_low_o)
  );

endmodule

// ===== src/bmf_checker.sv =====
// ----------------------------------------------------------------------------
// bmf_checker: port-level checks of the battery monitor filter
// Watches the handshakes of the top level and the spacing of samples.
// ----------------------------------------------------------------------------
module bmf_checker
  import bmf_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [MvW-1:0]  filtered_voltage_mv_o,
  input logic [CurW-1:0] filtered_current_ma_o,
  input logic            battery_low_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // A sample keeps the input closed for the four steps of its processing.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o ##1 in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input reopened before the sample was processed");

  // The input reopens only when a result has been placed in the output register.
  a_result_on_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input reopened without a result");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_voltage_mv_o)
      && $stable(filtered_current_ma_o) && $stable(battery_low_o))
    else $error("stalled result changed");

  // Once a result is taken while the input is idle, no new result shows up
  // until a further sample has started.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_stall_o |=> !out_valid_o || in_stall_o)
    else $error("result appeared without a sample in progress");

endmodule

bind battery_monitor_filter bmf_checker u_bmf_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .filtered_voltage_mv_o (filtered_voltage_mv_o),
  .filtered_current_ma_o (filtered_current_ma_o),
  .battery_low_o         (battery_low_o)
);
